>>> rtl/dxs_pkg.sv
// Shared types, code constants and bit helpers for the delta/XOR series encoder.
package dxs_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned LEN_W  = 7;

  localparam logic [LEN_W-1:0] LEN_WORD     = 7'd64;
  localparam logic [LEN_W-1:0] LEN_ONE      = 7'd1;
  localparam logic [LEN_W-1:0] LEN_TWO      = 7'd2;
  localparam logic [LEN_W-1:0] LEN_TS_7     = 7'd9;
  localparam logic [LEN_W-1:0] LEN_TS_9     = 7'd12;
  localparam logic [LEN_W-1:0] LEN_TS_12    = 7'd16;
  localparam logic [LEN_W-1:0] LEN_TS_32    = 7'd36;
  localparam logic [LEN_W-1:0] LEN_HEAD     = 7'd13;
  localparam logic [LEN_W-1:0] LEN_HEAD_MAX = 7'd51;
  localparam logic [LEN_W-1:0] LEN_REUSE_MAX = 7'd62;
  localparam logic [LEN_W-1:0] WIN_RESET    = 7'd64;
  localparam logic [LEN_W-1:0] LZ_CLAMP     = 7'd31;

  localparam logic [WORD_W-1:0] TS_PFX_7  = 64'd256;
  localparam logic [WORD_W-1:0] TS_PFX_9  = 64'd3072;
  localparam logic [WORD_W-1:0] TS_PFX_12 = 64'd57344;
  localparam logic [WORD_W-1:0] TS_PFX_32 = 64'd64424509440;
  localparam logic [WORD_W-1:0] TS_OFS_7  = 64'd63;
  localparam logic [WORD_W-1:0] TS_OFS_9  = 64'd255;
  localparam logic [WORD_W-1:0] TS_OFS_12 = 64'd2047;
  localparam logic [WORD_W-1:0] TS_SPAN_7  = 64'd127;
  localparam logic [WORD_W-1:0] TS_SPAN_9  = 64'd511;
  localparam logic [WORD_W-1:0] TS_SPAN_12 = 64'd4095;
  localparam logic [WORD_W-1:0] TS_LOW_32  = 64'd4294967295;
  localparam logic [WORD_W-1:0] VAL_REUSE_PFX = 64'd2;
  localparam logic [1:0]        VAL_NEW_PFX   = 2'b11;

  typedef struct packed {
    logic [WORD_W-1:0] bits;
    logic [LEN_W-1:0]  len;
  } chunk_t;

  typedef struct packed {
    logic              header_done;
    logic [WORD_W-1:0] last_time;
    logic [WORD_W-1:0] last_delta;
    logic [WORD_W-1:0] last_value;
    logic [LEN_W-1:0]  window_leading;
    logic [LEN_W-1:0]  window_trailing;
  } enc_state_t;

  typedef struct packed {
    chunk_t [2:0] chunk;
    logic [1:0]   last_idx;
    enc_state_t   next_state;
  } enc_result_t;

  function automatic logic [WORD_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [WORD_W-1:0] m;
    if (n >= LEN_WORD) begin
      m = '1;
    end else begin
      m = (64'd1 << n) - 64'd1;
    end
    return m;
  endfunction

  function automatic chunk_t make_chunk(input logic [WORD_W-1:0] bits,
                                        input logic [LEN_W-1:0] len);
    chunk_t c;
    c.bits = bits & low_mask(len);
    c.len  = len;
    return c;
  endfunction

  function automatic logic [LEN_W-1:0] count_leading(input logic [WORD_W-1:0] x);
    logic [LEN_W-1:0] n;
    n = LEN_WORD;
    for (int i = 0; i < WORD_W; i++) begin
      if (x[i]) n = LEN_W'(WORD_W - 1 - i);
    end
    return n;
  endfunction

  function automatic logic [LEN_W-1:0] count_trailing(input logic [WORD_W-1:0] x);
    logic [LEN_W-1:0] n;
    n = LEN_WORD;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (x[i]) n = LEN_W'(i);
    end
    return n;
  endfunction

endpackage

>>> rtl/dxs_encode.sv
// Single-pass encoder: builds the chunks of one sample and the next encoder state.
module dxs_encode #(
  parameter int unsigned FIRST_DELTA_BITS = 14
) (
  input  dxs_pkg::enc_state_t     st,
  input  logic [63:0]             block_start_time,
  input  logic [63:0]             time_stamp,
  input  logic [63:0]             sample_bits,
  output dxs_pkg::enc_result_t    res
);
  import dxs_pkg::*;

  logic [WORD_W-1:0] delta;
  logic [WORD_W-1:0] dod;
  logic [WORD_W-1:0] x;
  logic [LEN_W-1:0]  lz_raw;
  logic [LEN_W-1:0]  lz;
  logic [LEN_W-1:0]  tz;
  logic [LEN_W:0]    wsum;
  logic              reuse;
  logic [LEN_W-1:0]  rlen;
  logic [LEN_W-1:0]  nlen;
  logic [WORD_W-1:0] sig_r;
  logic [WORD_W-1:0] sig_n;
  logic [12:0]       head;
  chunk_t            ts_chunk;

  assign delta  = time_stamp - (st.header_done ? st.last_time : block_start_time);
  assign dod    = delta - st.last_delta;
  assign x      = sample_bits ^ st.last_value;
  assign lz_raw = count_leading(x);
  assign lz     = (lz_raw > LZ_CLAMP) ? LZ_CLAMP : lz_raw;
  assign tz     = count_trailing(x);
  assign wsum   = {1'b0, st.window_leading} + {1'b0, st.window_trailing};
  assign reuse  = (lz >= st.window_leading) && (tz >= st.window_trailing) &&
                  (wsum < {1'b0, LEN_WORD});
  assign rlen   = LEN_W'({1'b0, LEN_WORD} - wsum);
  assign nlen   = LEN_WORD - lz - tz;
  assign sig_r  = x >> st.window_trailing;
  assign sig_n  = x >> tz;
  assign head   = {VAL_NEW_PFX, lz[4:0], nlen[5:0]};

  always_comb begin
    priority if (dod == '0) begin
      ts_chunk = make_chunk('0, LEN_ONE);
    end else if (dod + TS_OFS_7 <= TS_SPAN_7) begin
      ts_chunk = make_chunk(TS_PFX_7 | ((dod + TS_OFS_7) & TS_SPAN_7), LEN_TS_7);
    end else if (dod + TS_OFS_9 <= TS_SPAN_9) begin
      ts_chunk = make_chunk(TS_PFX_9 | ((dod + TS_OFS_9) & TS_SPAN_9), LEN_TS_9);
    end else if (dod + TS_OFS_12 <= TS_SPAN_12) begin
      ts_chunk = make_chunk(TS_PFX_12 | ((dod + TS_OFS_12) & TS_SPAN_12), LEN_TS_12);
    end else begin
      ts_chunk = make_chunk(TS_PFX_32 | (dod & TS_LOW_32), LEN_TS_32);
    end
  end

  always_comb begin
    res = '0;
    res.next_state = st;
    res.next_state.last_delta = delta;
    res.next_state.last_time  = time_stamp;
    res.next_state.last_value = sample_bits;
    if (!st.header_done) begin
      res.chunk[0] = make_chunk(block_start_time, LEN_WORD);
      res.chunk[1] = make_chunk(delta, LEN_W'(FIRST_DELTA_BITS));
      res.chunk[2] = make_chunk(sample_bits, LEN_WORD);
      res.last_idx = 2'd2;
      res.next_state.header_done = 1'b1;
    end else begin
      res.chunk[0] = ts_chunk;
      priority if (x == '0) begin
        res.chunk[1] = make_chunk('0, LEN_ONE);
        res.last_idx = 2'd1;
      end else if (reuse) begin
        if (rlen > LEN_REUSE_MAX) begin
          res.chunk[1] = make_chunk(VAL_REUSE_PFX, LEN_TWO);
          res.chunk[2] = make_chunk(sig_r, rlen);
          res.last_idx = 2'd2;
        end else begin
          res.chunk[1] = make_chunk((VAL_REUSE_PFX << rlen) | sig_r, rlen + LEN_TWO);
          res.last_idx = 2'd1;
        end
      end else begin
        if (nlen <= LEN_HEAD_MAX) begin
          res.chunk[1] = make_chunk((WORD_W'(head) << nlen) | sig_n, nlen + LEN_HEAD);
          res.last_idx = 2'd1;
        end else begin
          res.chunk[1] = make_chunk(WORD_W'(head), LEN_HEAD);
          res.chunk[2] = make_chunk(sig_n, nlen);
          res.last_idx = 2'd2;
        end
        res.next_state.window_leading  = lz;
        res.next_state.window_trailing = tz;
      end
    end
  end

endmodule

>>> rtl/delta_xor_series_encoder_unit.sv
// Top level of the delta/XOR time series encoder: input item register, encoder, chunk buffer.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one sample per item: time_stamp and
//   sample_bits. Output channel (out_valid/out_stall) carries one code chunk per
//   item: chunk_bits (right aligned, MSB first), chunk_length and last_chunk.
//   block_start_time is written through cfg_we/cfg_wdata; the user must do so only while the
//   block is idle, which the block does not enforce. The first sample after reset yields
//   three chunks (start time, first delta, raw value); every later sample yields two or
//   three chunks. A sample accepted into the input register is encoded and loaded into
//   the chunk buffer when the buffer is empty or its last chunk is taken. The output port
//   moves one chunk per cycle while out_stall is low. The next sample is held in the input
//   register while the chunk buffer drains.
//   Reset clears the header flag and the history, returns the window to WIN_RESET, and
//   empties both the input register and the chunk buffer; block_start_time returns to zero.
//   When the receiver stalls, the current chunk holds; once the input register
//   is also full, in_stall rises.
module delta_xor_series_encoder_unit #(
  parameter int unsigned FIRST_DELTA_BITS = 14
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] time_stamp,
  input  logic [63:0] sample_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] chunk_bits,
  output logic [6:0]  chunk_length,
  output logic        last_chunk
);
  import dxs_pkg::*;

  logic [WORD_W-1:0] block_start_time;
  logic              in_full;
  logic [WORD_W-1:0] ts_q;
  logic [WORD_W-1:0] val_q;
  enc_state_t        st;
  enc_result_t       enc;
  chunk_t [2:0]      chunk_q;
  logic [1:0]        last_idx;
  logic [1:0]        idx;
  logic              buf_valid;
  logic              take;
  logic              drain_done;
  logic              load;
  logic              in_take;

  assign take       = buf_valid && !out_stall;
  assign drain_done = take && (idx == last_idx);
  assign load       = in_full && (!buf_valid || drain_done);
  assign in_stall   = in_full && !load;
  assign in_take    = in_valid && !in_stall;

  assign out_valid    = buf_valid;
  assign chunk_bits   = chunk_q[idx].bits;
  assign chunk_length = chunk_q[idx].len;
  assign last_chunk   = (idx == last_idx);

  dxs_encode #(
    .FIRST_DELTA_BITS(FIRST_DELTA_BITS)
  ) u_encode (
    .st              (st),
    .block_start_time(block_start_time),
    .time_stamp      (ts_q),
    .sample_bits     (val_q),
    .res             (enc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_start_time <= '0;
    end else if (cfg_we) begin
      block_start_time <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ts_q  <= time_stamp;
      val_q <= sample_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.header_done     <= 1'b0;
      st.last_time       <= '0;
      st.last_delta      <= '0;
      st.last_value      <= '0;
      st.window_leading  <= WIN_RESET;
      st.window_trailing <= WIN_RESET;
    end else if (load) begin
      st <= enc.next_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= '0;
      last_idx  <= '0;
    end else if (load) begin
      buf_valid <= 1'b1;
      idx       <= '0;
      last_idx  <= enc.last_idx;
    end else if (drain_done) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      chunk_q <= enc.chunk;
    end
  end

endmodule

>>> rtl/dxs_checker.sv
// Port-level checks for the encoder unit and their bind.
module dxs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] chunk_bits,
  input logic [6:0]  chunk_length,
  input logic        last_chunk
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(chunk_bits) &&
      $stable(chunk_length) && $stable(last_chunk))
    else $error("stalled chunk changed");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chunk_length != 7'd0) && (chunk_length <= 7'd64))
    else $error("chunk length out of range");

  a_bits_fit: assert property (@(posedge clk) disable iff (rst)
    out_valid && (chunk_length < 7'd64) |-> ((chunk_bits >> chunk_length) == 64'd0))
    else $error("chunk bits beyond length");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not empty after reset");

  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && !(last_chunk && !out_stall))
    else $error("input stalled while buffer can drain");

endmodule

bind delta_xor_series_encoder_unit dxs_checker u_dxs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .chunk_bits  (chunk_bits),
  .chunk_length(chunk_length),
  .last_chunk  (last_chunk)
);
